[design/ir_daf_pkg.sv]
// ----------------------------------------------------------------------------
// ir_daf_pkg
// shared types and constants of the ir distance average filter
// ----------------------------------------------------------------------------
package ir_daf_pkg;

  // sensor and averaging setup
  localparam int SENSOR_COUNT        = 3;
  localparam int SAMPLES_PER_CHANNEL = 4;

  // field widths
  localparam int SAMPLE_W = 12;
  localparam int CHAN_W   = 2;
  localparam int DIST_W   = 10;
  localparam int OFFSET_W = 4;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 1;

  // per-channel accumulator, saturating
  localparam int               SUM_W   = 14;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // sum to divisor: divide by samples per channel, then drop three more bits
  localparam int AVG_SHIFT = $clog2(SAMPLES_PER_CHANNEL) + 3;
  localparam int AVG_W     = SUM_W - AVG_SHIFT;

  // reciprocal divider, divisor one bit wider than the average for the bias
  localparam int                   NUM_W      = 12;
  localparam int                   DIVISOR_W  = AVG_W + 1;
  localparam int                   QUOT_W     = 10;
  localparam int                   DIV_CNT_W  = $clog2(NUM_W);
  localparam logic [NUM_W-1:0]     RECIP_NUM  = 12'd2914;
  localparam logic [DIVISOR_W-1:0] RECIP_BIAS = DIVISOR_W'(5);

  // filter sum, signed with room for prev + quotient
  localparam int                T_W      = 12;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // register reset values
  localparam logic [DIST_W-1:0]   CAP_RESET    = 10'd1023;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 4'd3;

  localparam logic [CHAN_W-1:0] LAST_SENSOR = CHAN_W'(SENSOR_COUNT - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISTANCE_CAP = 1'b0,
    REG_CALIB_OFFSET = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

[design/ir_daf_div.sv]
// ----------------------------------------------------------------------------
// ir_daf_div
// restoring divider, one quotient bit per cycle, fixed numerator
// ----------------------------------------------------------------------------
module ir_daf_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [ir_daf_pkg::DIVISOR_W-1:0]    divisor_i,
  output logic                                done_o,
  output logic [ir_daf_pkg::QUOT_W-1:0]       quot_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [ir_daf_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [ir_daf_pkg::NUM_W-1:0]        work_q, work_d;
  logic [ir_daf_pkg::DIVISOR_W-1:0]    rem_q, rem_d;
  logic [ir_daf_pkg::DIVISOR_W-1:0]    div_q, div_d;
  logic [ir_daf_pkg::DIVISOR_W:0]      shifted;
  logic [ir_daf_pkg::DIVISOR_W:0]      diff;
  logic                                fits;

  // trial subtract of the shifted remainder
  assign shifted = {rem_q, work_q[ir_daf_pkg::NUM_W-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign fits    = shifted >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      work_d = ir_daf_pkg::RECIP_NUM;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[ir_daf_pkg::DIVISOR_W-1:0] : shifted[ir_daf_pkg::DIVISOR_W-1:0];
      work_d = {work_q[ir_daf_pkg::NUM_W-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == ir_daf_pkg::DIV_CNT_W'(ir_daf_pkg::NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = work_q[ir_daf_pkg::QUOT_W-1:0];

endmodule

[design/ir_distance_average_filter.sv]
// ----------------------------------------------------------------------------
// ir_distance_average_filter
// per-sensor ir sample averaging, reciprocal distance and smoothing filter
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_ready_o   sample_i, channel_i, frame_end_i
//  out      output     out_valid_o / out_ready_i sensor_index_o, distance_cm_o, last_o
//  cfg      input      cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
//  a plain sample is summed into its channel at acceptance
//  a frame end then runs each sensor in turn: a start state, the bit-serial
//  divider, a filter step, then the result waits in the output register
//  until the output transaction takes it
//  no input transaction is taken until the last sensor's result is taken
//  reset clears sums and filtered distances and loads the register defaults
//
module ir_distance_average_filter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [ir_daf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ir_daf_pkg::CFG_W-1:0]         cfg_data_i,
  // sample channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [ir_daf_pkg::SAMPLE_W-1:0]      sample_i,
  input  logic [ir_daf_pkg::CHAN_W-1:0]        channel_i,
  input  logic                                 frame_end_i,
  // distance channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ir_daf_pkg::CHAN_W-1:0]        sensor_index_o,
  output logic [ir_daf_pkg::DIST_W-1:0]        distance_cm_o,
  output logic                                 last_o
);

  ir_daf_pkg::state_e state_q, state_d;

  // configuration registers
  logic [ir_daf_pkg::DIST_W-1:0]   cap_q;
  logic [ir_daf_pkg::OFFSET_W-1:0] offset_q;

  // per-sensor state
  logic [ir_daf_pkg::SUM_W-1:0]  sum_q  [ir_daf_pkg::SENSOR_COUNT];
  logic [ir_daf_pkg::DIST_W-1:0] filt_q [ir_daf_pkg::SENSOR_COUNT];

  // sensor being processed and the held result
  logic [ir_daf_pkg::CHAN_W-1:0] sensor_q, sensor_d;
  logic [ir_daf_pkg::DIST_W-1:0] dist_q;

  logic                               in_fire;
  logic                               chan_ok;
  logic [ir_daf_pkg::CHAN_W-1:0]      rd_idx;
  logic [ir_daf_pkg::SUM_W-1:0]       sum_rd;
  logic [ir_daf_pkg::SUM_W:0]         sum_add;
  logic [ir_daf_pkg::SUM_W-1:0]       sum_sat;
  logic [ir_daf_pkg::AVG_W-1:0]       avg;
  logic [ir_daf_pkg::DIVISOR_W-1:0]   divisor;
  logic [ir_daf_pkg::QUOT_W-1:0]      quot;
  logic [ir_daf_pkg::DIST_W-1:0]      prev;
  logic [ir_daf_pkg::T_W-1:0]         t_sum;
  logic [ir_daf_pkg::T_W-2:0]         t_half;
  logic [ir_daf_pkg::DIST_W-1:0]      filt_new;
  logic [ir_daf_pkg::DIST_W-1:0]      dist_capped;
  logic                               filt_we;
  logic                               div_start;
  logic                               div_done;

  assign in_fire = in_valid_i && in_ready_o;
  assign chan_ok = {1'b0, channel_i} < (ir_daf_pkg::CHAN_W + 1)'(ir_daf_pkg::SENSOR_COUNT);

  // one read port on the sums: the sample channel while idle, else the sensor
  assign rd_idx = (state_q == ir_daf_pkg::ST_IDLE) ? channel_i : sensor_q;
  assign sum_rd = sum_q[rd_idx];

  // saturating accumulate
  assign sum_add = {1'b0, sum_rd} + (ir_daf_pkg::SUM_W + 1)'(sample_i);
  assign sum_sat = sum_add[ir_daf_pkg::SUM_W] ? ir_daf_pkg::SUM_MAX
                                              : sum_add[ir_daf_pkg::SUM_W-1:0];

  // average, extra shift and bias form the divisor
  assign avg     = sum_rd[ir_daf_pkg::SUM_W-1:ir_daf_pkg::AVG_SHIFT];
  assign divisor = ir_daf_pkg::DIVISOR_W'(avg) + ir_daf_pkg::RECIP_BIAS;

  ir_daf_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // smoothing: (prev + reciprocal - offset) / 2, floored at zero
  assign prev   = filt_q[sensor_q];
  assign t_sum  = ir_daf_pkg::T_W'(prev) + ir_daf_pkg::T_W'(quot)
                - ir_daf_pkg::T_W'(offset_q);
  assign t_half = t_sum[ir_daf_pkg::T_W-1:1];

  always_comb begin
    if (t_sum[ir_daf_pkg::T_W-1]) begin
      filt_new = '0;
    end else if (t_half > (ir_daf_pkg::T_W - 1)'(ir_daf_pkg::DIST_MAX)) begin
      filt_new = ir_daf_pkg::DIST_MAX;
    end else begin
      filt_new = t_half[ir_daf_pkg::DIST_W-1:0];
    end
  end

  assign dist_capped = (filt_new < cap_q) ? filt_new : cap_q;

  // sequencer
  always_comb begin
    state_d    = state_q;
    sensor_d   = sensor_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    filt_we    = 1'b0;
    case (state_q)
      ir_daf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && frame_end_i) begin
          sensor_d = '0;
          state_d  = ir_daf_pkg::ST_START;
        end
      end
      ir_daf_pkg::ST_START: begin
        div_start = 1'b1;
        state_d   = ir_daf_pkg::ST_DIV;
      end
      ir_daf_pkg::ST_DIV: begin
        if (div_done) begin
          filt_we = 1'b1;
          state_d = ir_daf_pkg::ST_OUT;
        end
      end
      ir_daf_pkg::ST_OUT: begin
        if (out_ready_i) begin
          if (sensor_q == ir_daf_pkg::LAST_SENSOR) begin
            state_d = ir_daf_pkg::ST_IDLE;
          end else begin
            sensor_d = sensor_q + 1'b1;
            state_d  = ir_daf_pkg::ST_START;
          end
        end
      end
      default: begin
        state_d = ir_daf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ir_daf_pkg::ST_IDLE;
      sensor_q <= '0;
    end else begin
      state_q  <= state_d;
      sensor_q <= sensor_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= ir_daf_pkg::CAP_RESET;
      offset_q <= ir_daf_pkg::OFFSET_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ir_daf_pkg::REG_DISTANCE_CAP: cap_q    <= cfg_data_i;
        ir_daf_pkg::REG_CALIB_OFFSET: offset_q <= cfg_data_i[ir_daf_pkg::OFFSET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sums: accumulate on a sample; on filtering, clear the sum and store filt_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ir_daf_pkg::SENSOR_COUNT; i++) begin
        sum_q[i]  <= '0;
        filt_q[i] <= '0;
      end
    end else if (in_fire && chan_ok) begin
      sum_q[rd_idx] <= sum_sat;
    end else if (filt_we) begin
      sum_q[sensor_q]  <= '0;
      filt_q[sensor_q] <= filt_new;
    end
  end

  // result register, held until the output transaction
  always_ff @(posedge clk_i) begin
    if (filt_we) begin
      dist_q <= dist_capped;
    end
  end

  assign out_valid_o    = (state_q == ir_daf_pkg::ST_OUT);
  assign sensor_index_o = sensor_q;
  assign distance_cm_o  = dist_q;
  assign last_o         = (sensor_q == ir_daf_pkg::LAST_SENSOR);

`ifndef SYNTHESIS
  // the divider only reports while the sequencer waits on it
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ir_daf_pkg::ST_DIV))
    else $error("divider done outside divide state");

  // every new result comes straight from a finished division
  a_out_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(div_done))
    else $error("result raised without a division");

  // a sample is never taken while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while result pending");

  // the last flag sits on the final sensor only
  a_last_sensor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (sensor_index_o == ir_daf_pkg::LAST_SENSOR))
    else $error("last flag on wrong sensor");
`endif

endmodule
